/* hdl/pcm_rms_pkg.sv */
`timescale 1ns / 1ps
// Shared widths for the PCM16 RMS level meter.
// No dependencies; imported by pcm16_rms_level, pcm_rms_chk and the testbench.
package pcm_rms_pkg;

   localparam int SAMPLE_W   = 16;              // signed PCM word
   localparam int MAG_W      = SAMPLE_W + 1;    // magnitude up to 32768
   localparam int SQ_W       = 2 * SAMPLE_W - 1; // square up to 2**30
   localparam int MEAN_W     = 32;              // mean, padded to an even width
   localparam int RMS_W      = MEAN_W / 2;      // root bits, one per root step
   localparam int ROOT_STEPS = MEAN_W / 2;
   localparam int CNT_OUT_W  = 17;              // reported count field
   localparam int SQRT_REM_W = RMS_W + 4;       // partial remainder of root

   localparam logic [RMS_W-1:0] RMS_MAX = RMS_W'(32768);

endpackage

/* hdl/pcm16_rms_level.sv */
`timescale 1ns / 1ps
// RMS level meter for signed 16-bit PCM frames, with an iterative divider
// and square root sharing one compare/subtract unit. Depends on pcm_rms_pkg.
//
// Usage:
//   req_* carries one word per sample: req_sample, req_has_sample (0 for a
//   close-only word) and req_last (closes the frame). A word is taken on a
//   rising edge with req_valid high and req_stall low.
//   rsp_* carries one word per closed frame: rsp_rms = floor(sqrt(floor(
//   sum of squares / count))), rsp_samples_counted (low 17 bits of count)
//   and rsp_overflow (samples were dropped once the frame held MAX_SAMPLES).
//   An empty frame reports rms 0 and count 0.
// Flow:
//   Words without last are taken one per cycle while the input is open. A
//   word with last holds the input stalled while the frame is finished: a
//   flush step folds in the last square, then SUM_W restoring-divide steps
//   (SUM_W = 30 + clog2(MAX_SAMPLES + 1)) and 16 root steps, all through the
//   one shared subtractor, then a result step loads the output register once
//   it is free. An empty frame skips the divide.
//   The result word shows on rsp_* as the input reopens.
// Stall and reset:
//   The result register holds its word while rsp_stall is high; the input
//   keeps taking samples meanwhile, and a second finished frame waits in the
//   result step, input stalled, until the register frees. Synchronous reset
//   clears the frame state and drops any pending result.
module pcm16_rms_level
   import pcm_rms_pkg::*;
#(
   parameter int MAX_SAMPLES = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [SAMPLE_W-1:0]  req_sample,
   input  logic                 req_has_sample,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [RMS_W-1:0]     rsp_rms,
   output logic [CNT_OUT_W-1:0] rsp_samples_counted,
   output logic                 rsp_overflow
);

   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W  = SQ_W - 1 + CNT_W;
   localparam int REM_W  = (CNT_W + 1 > SQRT_REM_W) ? CNT_W + 1 : SQRT_REM_W;
   localparam int STEP_W = $clog2(SUM_W);
   localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_SAMPLES);
   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);
   localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_STEPS - 1);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_FLUSH  = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_SQRT   = 3'd3;
   localparam logic [2:0] S_RESULT = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   logic [SQ_W-1:0]        sq_ff, sq_in;
   logic                   pend_ff, pend_in;
   logic [SUM_W-1:0]       dvd_ff, dvd_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [MEAN_W-1:0]      mean_ff, mean_in;
   logic [RMS_W-1:0]       root_ff, root_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RMS_W-1:0]       rsp_rms_ff, rsp_rms_in;
   logic [CNT_OUT_W-1:0]   rsp_cnt_ff, rsp_cnt_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   logic                   req_take;
   logic                   rsp_free;
   logic [MAG_W-1:0]       mag;
   logic [2*MAG_W-1:0]     mag_sq;
   logic [REM_W-1:0]       sub_a, sub_b;
   logic [REM_W:0]         diff;
   logic                   fits;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Magnitude of the two's complement word: negate the sign-extended value.
   assign mag    = req_sample[SAMPLE_W-1] ? (MAG_W'(0) - {1'b1, req_sample})
                                          : {1'b0, req_sample};
   assign mag_sq = mag * mag;

   // Shared compare/subtract unit: the divider and the root each feed it
   // a shifted partial remainder and a trial subtrahend.
   always_comb begin
      unique case (state_ff)
         S_DIV: begin
            sub_a = {rem_ff[REM_W-2:0], dvd_ff[SUM_W-1]};
            sub_b = REM_W'(count_ff);
         end
         S_SQRT: begin
            sub_a = {rem_ff[REM_W-3:0], mean_ff[MEAN_W-1 -: 2]};
            sub_b = REM_W'({root_ff, 2'b01});
         end
         default: begin
            sub_a = '0;
            sub_b = '0;
         end
      endcase
   end

   assign diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign fits = !diff[REM_W];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      sq_in        = sq_ff;
      pend_in      = 1'b0;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      mean_in      = mean_ff;
      root_in      = root_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_rms_in   = rsp_rms_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      // Fold the square registered on the previous cycle into the sum.
      sum_in = pend_ff ? (sum_ff + SUM_W'(sq_ff)) : sum_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_has_sample) begin
                  if (count_ff < MAX_CNT) begin
                     sq_in    = mag_sq[SQ_W-1:0];
                     pend_in  = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               if (req_last) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            // Sum is final this cycle; skip the divide for an empty frame.
            dvd_in  = sum_in;
            rem_in  = '0;
            root_in = '0;
            step_in = '0;
            mean_in = '0;
            if (count_ff == '0) begin
               state_in = S_SQRT;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            dvd_in  = {dvd_ff[SUM_W-2:0], fits};
            rem_in  = fits ? diff[REM_W-1:0] : sub_a;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == DIV_LAST) begin
               // Quotient never exceeds 2**30; take it as the mean.
               mean_in  = MEAN_W'(dvd_in[SQ_W-1:0]);
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            rem_in  = fits ? diff[REM_W-1:0] : sub_a;
            root_in = {root_ff[RMS_W-2:0], fits};
            mean_in = {mean_ff[MEAN_W-3:0], 2'b00};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == ROOT_LAST) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            // Hold here until the output register frees, then clear the frame.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_rms_in   = root_ff;
               rsp_cnt_in   = CNT_OUT_W'(count_ff);
               rsp_ovf_in   = ovf_ff;
               sum_in       = '0;
               count_in     = '0;
               ovf_in       = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff      <= sq_in;
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      mean_ff    <= mean_in;
      root_ff    <= root_in;
      step_ff    <= step_in;
      rsp_rms_ff <= rsp_rms_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_rms             = rsp_rms_ff;
   assign rsp_samples_counted = rsp_cnt_ff;
   assign rsp_overflow        = rsp_ovf_ff;

endmodule

/* hdl/pcm_rms_chk.sv */
`timescale 1ns / 1ps
// Port-level checker for pcm16_rms_level, bound to every instance.
// Depends on pcm_rms_pkg.
module pcm_rms_chk
   import pcm_rms_pkg::*;
#(
   parameter int MAX_SAMPLES = 65536
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 req_last,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [RMS_W-1:0]     rsp_rms,
   input logic [CNT_OUT_W-1:0] rsp_samples_counted,
   input logic                 rsp_overflow
);

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_rms) && $stable(rsp_samples_counted)
                                 && $stable(rsp_overflow))
      else $error("stalled result word changed");

   // a frame close starts the flush, so the input must stall next cycle
   a_close_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last |=> req_stall)
      else $error("input not stalled after frame close");

   // root of a 16-bit mean square never exceeds full scale
   a_rms_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rms[RMS_W-1] |-> rsp_rms == RMS_MAX)
      else $error("rms above full scale");

   // overflow only once the frame is full
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_samples_counted == CNT_OUT_W'(MAX_SAMPLES))
      else $error("overflow flagged on a frame that was not full");

endmodule

bind pcm16_rms_level pcm_rms_chk #(.MAX_SAMPLES(MAX_SAMPLES)) u_pcm_rms_chk (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_last            (req_last),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_rms             (rsp_rms),
   .rsp_samples_counted (rsp_samples_counted),
   .rsp_overflow        (rsp_overflow)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for pcm16_rms_level: frames of PCM words go in, and each closing
// word's RMS level is predicted and compared field by field. Depends on pcm_rms_pkg.
module testbench;
   import pcm_rms_pkg::*;

   localparam int MAX_FRAME   = 65536;     // samples kept per frame, as built into the DUT
   localparam int CYCLE_LIMIT = 1000000;   // hard stop; a correct run needs well under this
   localparam int TAIL_CYCLES = 100;       // extra cycles run after the final drain

   // One RMS result word as the DUT should report it.
   typedef struct packed {
      logic [RMS_W-1:0]     rms;
      logic [CNT_OUT_W-1:0] count;
      logic                 ovf;
   } frame_level_type;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   logic [SAMPLE_W-1:0]  req_sample     = '0;
   logic                 req_has_sample = 1'b0;
   logic                 req_last       = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   logic [RMS_W-1:0]     rsp_rms;
   logic [CNT_OUT_W-1:0] rsp_samples_counted;
   logic                 rsp_overflow;

   // Predictor copy of the open frame.
   logic [47:0]  frame_sum     = '0;
   int unsigned  frame_count   = 0;
   logic         frame_dropped = 1'b0;

   frame_level_type pending_levels[$];   // predicted levels, oldest first
   int           err_count      = 0;
   int           cycle_count    = 0;
   int           send_gap_pct   = 0;  // chance per cycle that the sender holds off
   int           rsp_stall_pct  = 0;  // chance per cycle that the receiver stalls

   pcm16_rms_level #(.MAX_SAMPLES(MAX_FRAME)) DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample          (req_sample),
      .req_has_sample      (req_has_sample),
      .req_last            (req_last),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_rms             (rsp_rms),
      .rsp_samples_counted (rsp_samples_counted),
      .rsp_overflow        (rsp_overflow)
   );

   always #2 clock = ~clock;

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** pcm16_rms_level: FAILED **");
         $finish;
      end
   end

   // Random back-pressure on the result channel; the chance changes per phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   task automatic report_error(input string msg);
      $display("[%0t] ERROR: %s", $realtime, msg);
      err_count++;
   endtask

   // Floor of the square root, found one root bit at a time from the top.
   function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
      logic [31:0] root;
      logic [31:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (32'd1 << b);
         if (64'(trial) * 64'(trial) <= v) root = trial;
      end
      return root;
   endfunction

   // Fold one accepted word into the frame; on a closing word, queue the level and
   // clear the frame for the next one.
   task automatic fold_word(input logic [SAMPLE_W-1:0] s, input bit has, input bit lst);
      logic [SAMPLE_W:0] mag;
      frame_level_type   lvl;
      if (has) begin
         if (frame_count < MAX_FRAME) begin
            // magnitude of the two's complement value; -32768 becomes 32768
            mag = s[SAMPLE_W-1] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
            frame_sum += 48'(mag) * 48'(mag);
            frame_count++;
         end else begin
            frame_dropped = 1'b1;
         end
      end
      if (lst) begin
         lvl.rms   = (frame_count == 0) ? '0
                   : RMS_W'(floor_sqrt(64'(frame_sum) / 64'(frame_count)));
         lvl.count = CNT_OUT_W'(frame_count);
         lvl.ovf   = frame_dropped;
         pending_levels.push_back(lvl);
         frame_sum     = '0;
         frame_count   = 0;
         frame_dropped = 1'b0;
      end
   endtask

   // Send one word. Entered and left just after a rising edge. Valid stays high
   // across back-to-back words so it never gets two updates in one step.
   task automatic send_word(input logic [SAMPLE_W-1:0] s, input bit has, input bit lst);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_sample     <= s;
      req_has_sample <= has;
      req_last       <= lst;
      // Stall is settled by the falling edge; the word moves on the next rising edge.
      do @(negedge clock); while (req_stall);
      fold_word(s, has, lst);
      @(posedge clock);
   endtask

   // Hold the sender until every predicted level has come back.
   task automatic drain_levels();
      req_valid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
   endtask

   // Mostly full-range values, with extremes and small amplitudes mixed in.
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'(signed'($urandom_range(0, 64)) - 32);
         3:       return 16'($urandom_range(0, 3)) ^ {16{1'($urandom_range(1))}};
         default: return 16'($urandom);
      endcase
   endfunction

   // Empty frames, including a close-only word whose sample field is junk.
   task automatic test_empty_frames();
      send_word(16'h0000, 1'b0, 1'b1);
      send_word(16'hFFFF, 1'b0, 1'b1);
      send_word(16'h8000, 1'b0, 1'b1);
   endtask

   // Single-sample frames at the extremes, the sample riding on the closing word,
   // and short mixed frames closed both with and without a sample.
   task automatic test_extreme_samples();
      send_word(16'h8000, 1'b1, 1'b1);   // full negative scale -> 32768
      send_word(16'h7FFF, 1'b1, 1'b1);   // full positive scale -> 32767
      send_word(16'h0000, 1'b1, 1'b1);
      send_word(16'hFFFF, 1'b1, 1'b1);   // -1
      send_word(16'd100,  1'b1, 1'b0);
      send_word(-16'sd100, 1'b1, 1'b0);
      send_word(16'h8000, 1'b0, 1'b0);   // ignored: no sample
      send_word(16'd3,    1'b1, 1'b1);
      send_word(16'h8000, 1'b1, 1'b0);
      send_word(16'h7FFF, 1'b1, 1'b0);
      send_word(16'h0000, 1'b1, 1'b0);
      send_word(16'hFFFF, 1'b1, 1'b0);
      send_word(16'h5555, 1'b0, 1'b1);   // close-only
      send_word(16'hAAAA, 1'b1, 1'b0);
      send_word(16'h5555, 1'b1, 1'b1);
   endtask

   // Well-formed frames of random length and content; some words inside a frame
   // carry no sample, and the closing word carries one half the time.
   task automatic test_random_frames(input int n_words);
      int sent;
      int len;
      bit has;
      sent = 0;
      while (sent < n_words) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(16, 80) : $urandom_range(0, 12);
         for (int i = 0; i < len; i++) begin
            has = ($urandom_range(9) != 0);
            send_word(pick_sample(), has, 1'b0);
            if (has) sent++;
         end
         send_word(pick_sample(), 1'($urandom_range(1)), 1'b1);
         sent++;
      end
   endtask

   // Compare each accepted result word against the oldest prediction. Sample at the
   // falling edge, where valid, stall and payload are settled for the coming edge.
   always @(negedge clock) begin : check_levels
      frame_level_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_levels.size() == 0) begin
            report_error($sformatf("unexpected result word rms=%0d count=%0d ovf=%0b",
                                   rsp_rms, rsp_samples_counted, rsp_overflow));
         end else begin
            want = pending_levels.pop_front();
            if (rsp_rms !== want.rms)
               report_error($sformatf("rms got %0d expected %0d", rsp_rms, want.rms));
            if (rsp_samples_counted !== want.count)
               report_error($sformatf("samples_counted got %0d expected %0d",
                                      rsp_samples_counted, want.count));
            if (rsp_overflow !== want.ovf)
               report_error($sformatf("overflow got %0b expected %0b",
                                      rsp_overflow, want.ovf));
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Phase 1: sender rarely idles, receiver stalls often.
      send_gap_pct  = 9;
      rsp_stall_pct = 62;
      test_empty_frames();
      test_extreme_samples();
      test_random_frames(180);
      drain_levels();

      // Phase 2: sender idles often, receiver rarely stalls.
      send_gap_pct  = 62;
      rsp_stall_pct = 9;
      test_random_frames(180);
      drain_levels();

      // Phase 3: no idling on either side.
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      test_random_frames(180);

      drain_levels();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0 && pending_levels.size() == 0) begin
         $display("** pcm16_rms_level: PASSED **");
      end else begin
         $display("** pcm16_rms_level: FAILED **");
      end
      $finish;
   end

endmodule
